### rtl/core/dcfb_pkg.sv
// ----------------------------------------------------------------------------
// dcfb_pkg: shared types and constants of the daisy-chain frame builder
// Command codes, register indexes, the job record passed from front to back,
// and the reflected CRC-8 byte step.
// ----------------------------------------------------------------------------
package dcfb_pkg;

   typedef enum logic [2:0] {
      CMD_ENUMERATE    = 3'd0,
      CMD_WRITE_BCAST  = 3'd1,
      CMD_WRITE_DEVICE = 3'd2,
      CMD_READ_BCAST   = 3'd3,
      CMD_READ_DEVICE  = 3'd4,
      CMD_RESPONSE     = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      REG_LOAD_QUEUE   = 3'd0,
      REG_HELLO        = 3'd1,
      REG_WRITE_ALL    = 3'd2,
      REG_READ_ALL     = 3'd3,
      REG_MODULE_COUNT = 3'd4
   } reg_index_type;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned JOB_BYTES   = 8;
   localparam int unsigned SENT_BYTES  = 5;

   localparam logic [7:0] CRC_POLY          = 8'hB2;
   localparam logic [2:0] DEV_WRITE_TAG     = 3'b100;
   localparam logic [2:0] DEV_READ_TAG      = 3'b101;
   localparam logic [7:0] HELLO_LEN         = 8'd3;
   localparam logic [7:0] WRITE_LEN         = 8'd6;
   localparam logic [7:0] READ_DEVICE_LEN   = 8'd7;
   localparam logic [7:0] READ_ALL_BASE_LEN = 8'd5;
   localparam logic [2:0] HELLO_LAST        = 3'd4;
   localparam logic [2:0] WRITE_LAST        = 3'd7;
   localparam logic [2:0] READ_LAST         = 3'd6;
   localparam logic [6:0] POS_MAX           = 7'd127;
   localparam logic [6:0] POS_CAPTURE       = 7'd2;
   localparam logic [6:0] POS_ECHO_END      = 7'd5;

   localparam logic [7:0] RESET_LOAD_QUEUE  = 8'd192;
   localparam logic [7:0] RESET_HELLO       = 8'd87;
   localparam logic [7:0] RESET_WRITE_ALL   = 8'd2;
   localparam logic [7:0] RESET_READ_ALL    = 8'd3;
   localparam logic [4:0] RESET_MODULE_CNT  = 5'd1;

   typedef struct packed {
      logic [7:0] load_queue_opcode;
      logic [7:0] hello_opcode;
      logic [7:0] write_all_opcode;
      logic [7:0] read_all_opcode;
      logic [4:0] module_count;
   } cfg_type;

   // One unit of output work: a whole frame or one check report
   typedef struct packed {
      logic                           is_report;
      logic [JOB_BYTES-1:0][7:0]      frame_bytes;
      logic [2:0]                     last_index;
      logic                           echo_ok;
      logic                           crc_ok;
      logic                           alive_ok;
      logic [7:0]                     found_count;
   } job_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] frame_byte;
      logic       frame_last;
      logic       echo_ok;
      logic       crc_ok;
      logic       alive_ok;
      logic [7:0] found_count;
   } result_type;

   // Reflected CRC-8, LSB first
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### rtl/core/dcfb_front.sv
// ----------------------------------------------------------------------------
// dcfb_front: request intake and classification
// Builds frames for commands, tracks response checks, and pushes one job
// per frame or report into the queue.
// ----------------------------------------------------------------------------
module dcfb_front (
   input  logic                clock,
   input  logic                reset,
   input  dcfb_pkg::cfg_type   cfg,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [2:0]          req_cmd,
   input  logic [7:0]          req_reg_address,
   input  logic [15:0]         req_write_value,
   input  logic [4:0]          req_module_index,
   input  logic [7:0]          req_resp_byte,
   input  logic                req_resp_last,
   output logic                push,
   output dcfb_pkg::job_type   job
);

   dcfb_pkg::cmd_type pending_ff, pending_in;
   logic [7:0]        sent_ff [dcfb_pkg::SENT_BYTES];
   logic [7:0]        sent_in [dcfb_pkg::SENT_BYTES];
   logic              sent_we;
   logic [6:0]        pos_ff, pos_in;
   logic [7:0]        crc_ff, crc_in;
   logic [7:0]        dly0_ff, dly0_in;
   logic [7:0]        dly1_ff, dly1_in;
   logic              echo_ff, echo_in;
   logic [7:0]        hello_ff, hello_in;

   logic              accept;
   logic [7:0]        m0;
   logic [7:0]        crc_w;
   logic [7:0]        crc_r;
   logic [7:0]        read_len;
   logic [7:0]        expect_alive;
   logic              echo_new;
   logic [7:0]        crc_new;
   logic [7:0]        hello_new;

   assign accept = req_valid && !req_stall;

   // Module command byte of the request on the port, and the frame CRCs
   always_comb begin
      unique case (req_cmd)
         dcfb_pkg::CMD_ENUMERATE:    m0 = cfg.hello_opcode;
         dcfb_pkg::CMD_WRITE_BCAST:  m0 = cfg.write_all_opcode;
         dcfb_pkg::CMD_WRITE_DEVICE: m0 = {req_module_index, dcfb_pkg::DEV_WRITE_TAG};
         dcfb_pkg::CMD_READ_BCAST:   m0 = cfg.read_all_opcode;
         dcfb_pkg::CMD_READ_DEVICE:  m0 = {req_module_index, dcfb_pkg::DEV_READ_TAG};
         default:                    m0 = 8'd0;
      endcase
      crc_w = dcfb_pkg::crc_byte(8'd0, m0);
      crc_w = dcfb_pkg::crc_byte(crc_w, req_reg_address);
      crc_w = dcfb_pkg::crc_byte(crc_w, req_write_value[7:0]);
      crc_w = dcfb_pkg::crc_byte(crc_w, req_write_value[15:8]);
      crc_r = dcfb_pkg::crc_byte(8'd0, m0);
      crc_r = dcfb_pkg::crc_byte(crc_r, req_reg_address);
      crc_r = dcfb_pkg::crc_byte(crc_r, 8'd0);
   end

   assign read_len = dcfb_pkg::READ_ALL_BASE_LEN + {2'b00, cfg.module_count, 1'b0};

   // Response byte updates, before the last-byte decision
   always_comb begin
      echo_new = echo_ff;
      if (pos_ff < dcfb_pkg::POS_ECHO_END) begin
         if (req_resp_byte != sent_ff[pos_ff[2:0]]) begin
            echo_new = 1'b0;
         end
      end
      hello_new = (pos_ff == dcfb_pkg::POS_CAPTURE) ? req_resp_byte : hello_ff;
      crc_new   = (pos_ff >= dcfb_pkg::POS_CAPTURE) ? dcfb_pkg::crc_byte(crc_ff, dly1_ff)
                                                    : crc_ff;
      expect_alive = (pending_ff == dcfb_pkg::CMD_WRITE_DEVICE ||
                      pending_ff == dcfb_pkg::CMD_READ_DEVICE) ? 8'd1
                                                               : {3'b000, cfg.module_count};
   end

   always_comb begin
      pending_in = pending_ff;
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      dly0_in    = dly0_ff;
      dly1_in    = dly1_ff;
      echo_in    = echo_ff;
      hello_in   = hello_ff;
      sent_we    = 1'b0;
      for (int i = 0; i < dcfb_pkg::SENT_BYTES; i++) begin
         sent_in[i] = 8'd0;
      end
      push = 1'b0;
      job  = '0;
      if (accept) begin
         unique case (req_cmd)
            dcfb_pkg::CMD_ENUMERATE: begin
               sent_in[0] = m0;
               job.frame_bytes[0] = cfg.load_queue_opcode;
               job.frame_bytes[1] = dcfb_pkg::HELLO_LEN;
               job.frame_bytes[2] = m0;
               job.last_index = dcfb_pkg::HELLO_LAST;
            end
            dcfb_pkg::CMD_WRITE_BCAST, dcfb_pkg::CMD_WRITE_DEVICE: begin
               sent_in[0] = m0;
               sent_in[1] = req_reg_address;
               sent_in[2] = req_write_value[7:0];
               sent_in[3] = req_write_value[15:8];
               sent_in[4] = crc_w;
               job.frame_bytes[0] = cfg.load_queue_opcode;
               job.frame_bytes[1] = dcfb_pkg::WRITE_LEN;
               job.frame_bytes[2] = m0;
               job.frame_bytes[3] = req_reg_address;
               job.frame_bytes[4] = req_write_value[7:0];
               job.frame_bytes[5] = req_write_value[15:8];
               job.frame_bytes[6] = crc_w;
               job.last_index = dcfb_pkg::WRITE_LAST;
            end
            dcfb_pkg::CMD_READ_BCAST, dcfb_pkg::CMD_READ_DEVICE: begin
               sent_in[0] = m0;
               sent_in[1] = req_reg_address;
               sent_in[3] = crc_r;
               job.frame_bytes[0] = cfg.load_queue_opcode;
               job.frame_bytes[1] = (req_cmd == dcfb_pkg::CMD_READ_BCAST) ? read_len
                                                              : dcfb_pkg::READ_DEVICE_LEN;
               job.frame_bytes[2] = m0;
               job.frame_bytes[3] = req_reg_address;
               job.frame_bytes[5] = crc_r;
               job.last_index = dcfb_pkg::READ_LAST;
            end
            dcfb_pkg::CMD_RESPONSE: begin
               echo_in  = echo_new;
               hello_in = hello_new;
               crc_in   = crc_new;
               if (!req_resp_last) begin
                  dly1_in = dly0_ff;
                  dly0_in = req_resp_byte;
                  if (pos_ff < dcfb_pkg::POS_MAX) begin
                     pos_in = pos_ff + 7'd1;
                  end
               end
            end
            default: begin
            end
         endcase

         // Commands: store module bytes, take new kind, clear accumulators
         if (req_cmd <= dcfb_pkg::CMD_READ_DEVICE) begin
            sent_we    = 1'b1;
            pending_in = dcfb_pkg::cmd_type'(req_cmd);
            push       = 1'b1;
         end

         // Last response byte: report against the pending kind
         if (req_cmd == dcfb_pkg::CMD_RESPONSE && req_resp_last) begin
            push = 1'b1;
            job.is_report = 1'b1;
            priority if (pending_ff == dcfb_pkg::CMD_ENUMERATE) begin
               job.found_count = hello_new;
            end else if (pending_ff == dcfb_pkg::CMD_WRITE_BCAST ||
                         pending_ff == dcfb_pkg::CMD_WRITE_DEVICE) begin
               job.echo_ok  = echo_new && (pos_ff >= dcfb_pkg::POS_ECHO_END);
               job.alive_ok = (req_resp_byte == expect_alive);
            end else begin
               job.crc_ok   = (crc_new == dly0_ff);
               job.alive_ok = (req_resp_byte == expect_alive);
            end
         end

         if (push) begin
            pos_in   = '0;
            crc_in   = '0;
            dly0_in  = '0;
            dly1_in  = '0;
            echo_in  = 1'b1;
            hello_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= dcfb_pkg::CMD_ENUMERATE;
         pos_ff     <= '0;
         crc_ff     <= '0;
         dly0_ff    <= '0;
         dly1_ff    <= '0;
         echo_ff    <= 1'b1;
         hello_ff   <= '0;
      end else begin
         pending_ff <= pending_in;
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         dly0_ff    <= dly0_in;
         dly1_ff    <= dly1_in;
         echo_ff    <= echo_in;
         hello_ff   <= hello_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sent_we) begin
         sent_ff <= sent_in;
      end
   end

endmodule

### rtl/core/dcfb_queue.sv
// ----------------------------------------------------------------------------
// dcfb_queue: job queue between front and back
// Small circular buffer; full stops the front, empty idles the back.
// ----------------------------------------------------------------------------
module dcfb_queue #(
   parameter int unsigned DEPTH = dcfb_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dcfb_pkg::job_type   push_job,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output dcfb_pkg::job_type   head_job
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   dcfb_pkg::job_type  slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

### rtl/core/dcfb_back.sv
// ----------------------------------------------------------------------------
// dcfb_back: job execution and result output
// Walks each frame one byte per cycle, or sends a report, into an output
// register that is held while the result side stalls.
// ----------------------------------------------------------------------------
module dcfb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  dcfb_pkg::job_type     head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dcfb_pkg::result_type  rsp
);

   dcfb_pkg::job_type    cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [2:0]           idx_ff, idx_in;
   logic                 out_valid_ff, out_valid_in;
   dcfb_pkg::result_type out_ff, out_in;
   logic                 out_free;
   logic                 advance;
   logic                 done;
   logic                 load_cur;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign advance  = cur_valid_ff && out_free;
   assign done     = advance && (cur_ff.is_report || idx_ff == cur_ff.last_index);
   assign load_cur = !cur_valid_ff || done;
   assign pop      = load_cur && head_valid;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = '0;
         if (cur_ff.is_report) begin
            out_in.result_kind = 1'b1;
            out_in.echo_ok     = cur_ff.echo_ok;
            out_in.crc_ok      = cur_ff.crc_ok;
            out_in.alive_ok    = cur_ff.alive_ok;
            out_in.found_count = cur_ff.found_count;
         end else begin
            out_in.frame_byte = cur_ff.frame_bytes[idx_ff];
            out_in.frame_last = (idx_ff == cur_ff.last_index);
         end
         idx_in = idx_ff + 3'd1;
      end
      // Take the next job with no gap behind the finished one
      if (load_cur) begin
         cur_valid_in = head_valid;
         cur_in       = head_job;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

### rtl/core/daisy_chain_frame_build_check_top.sv
// ----------------------------------------------------------------------------
// daisy_chain_frame_build_check_top: daisy-chain frame builder and checker
// Builds outgoing battery-monitor chain frames and checks their responses.
// ----------------------------------------------------------------------------
// A request is accepted on any cycle where req_valid is high and req_stall is
// low. Commands hello-all, write-all, write-device, read-all and read-device
// each produce one outgoing frame (load-queue byte, length byte, module bytes
// with reflected CRC-8 on writes and reads, alive seed) of 5, 8 or 7 result
// items; response bytes (cmd 5) are taken one per cycle while the queue is not
// full, and the byte marked last produces a single check report. The front
// takes one request every cycle while the queue is not full; the result port
// delivers one item per cycle unless stalled, so a stream of commands is paced
// by the frame length through a queue of QUEUE_DEPTH jobs. With nothing
// stalled, the first result item of a request passes the queue slot, the
// current-job register and the output register before the result port.
// Configure the registers over the APB port only while the block is idle.
// ----------------------------------------------------------------------------
module daisy_chain_frame_build_check_top #(
   parameter int unsigned QUEUE_DEPTH = dcfb_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_reg_address,
   input  logic [15:0] req_write_value,
   input  logic [4:0]  req_module_index,
   input  logic [7:0]  req_resp_byte,
   input  logic        req_resp_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_last,
   output logic        rsp_echo_ok,
   output logic        rsp_crc_ok,
   output logic        rsp_alive_ok,
   output logic [7:0]  rsp_found_count,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   dcfb_pkg::cfg_type    cfg_ff, cfg_in;
   dcfb_pkg::job_type    push_job;
   dcfb_pkg::job_type    head_job;
   dcfb_pkg::result_type rsp;
   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 head_valid;
   logic                 cfg_write;
   dcfb_pkg::reg_index_type reg_sel;

   // Registers sit at byte address 4*index; low two address bits are ignored
   assign pready    = 1'b1;
   assign reg_sel   = dcfb_pkg::reg_index_type'(paddr[4:2]);
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (reg_sel)
            dcfb_pkg::REG_LOAD_QUEUE:   cfg_in.load_queue_opcode = pwdata[7:0];
            dcfb_pkg::REG_HELLO:        cfg_in.hello_opcode      = pwdata[7:0];
            dcfb_pkg::REG_WRITE_ALL:    cfg_in.write_all_opcode  = pwdata[7:0];
            dcfb_pkg::REG_READ_ALL:     cfg_in.read_all_opcode   = pwdata[7:0];
            dcfb_pkg::REG_MODULE_COUNT: cfg_in.module_count      = pwdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // Read back, zero-extended
   always_comb begin
      unique case (reg_sel)
         dcfb_pkg::REG_LOAD_QUEUE:   prdata = {24'd0, cfg_ff.load_queue_opcode};
         dcfb_pkg::REG_HELLO:        prdata = {24'd0, cfg_ff.hello_opcode};
         dcfb_pkg::REG_WRITE_ALL:    prdata = {24'd0, cfg_ff.write_all_opcode};
         dcfb_pkg::REG_READ_ALL:     prdata = {24'd0, cfg_ff.read_all_opcode};
         dcfb_pkg::REG_MODULE_COUNT: prdata = {27'd0, cfg_ff.module_count};
         default:                    prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.load_queue_opcode <= dcfb_pkg::RESET_LOAD_QUEUE;
         cfg_ff.hello_opcode      <= dcfb_pkg::RESET_HELLO;
         cfg_ff.write_all_opcode  <= dcfb_pkg::RESET_WRITE_ALL;
         cfg_ff.read_all_opcode   <= dcfb_pkg::RESET_READ_ALL;
         cfg_ff.module_count      <= dcfb_pkg::RESET_MODULE_CNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold requests off while the job queue is full
   assign req_stall = queue_full;

   dcfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_reg_address  (req_reg_address),
      .req_write_value  (req_write_value),
      .req_module_index (req_module_index),
      .req_resp_byte    (req_resp_byte),
      .req_resp_last    (req_resp_last),
      .push             (push),
      .job              (push_job)
   );

   dcfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   dcfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // Fan out the result record onto the per-field ports
   assign rsp_result_kind = rsp.result_kind;
   assign rsp_frame_byte  = rsp.frame_byte;
   assign rsp_frame_last  = rsp.frame_last;
   assign rsp_echo_ok     = rsp.echo_ok;
   assign rsp_crc_ok      = rsp.crc_ok;
   assign rsp_alive_ok    = rsp.alive_ok;
   assign rsp_found_count = rsp.found_count;

endmodule

### verif/daisy_chain_frame_build_check_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daisy_chain_frame_build_check_top_test: frame builder and response checker
// Feeds chain commands and response byte streams through the request port,
// predicts every outgoing frame byte and check report in step with the
// accepted requests, and compares them field by field as they leave. Register
// settings change between phases, and both ports idle and stall at random.
// ----------------------------------------------------------------------------
module daisy_chain_frame_build_check_top_test;

   // Command codes the block must ignore
   localparam logic [2:0]  CMD_SPARE_6  = 3'd6;
   localparam logic [2:0]  CMD_SPARE_7  = 3'd7;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int          PHASE_ITEMS  = 80;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  reg_address;
      logic [15:0] write_value;
      logic [4:0]  module_index;
      logic [7:0]  resp_byte;
      logic        resp_last;
   } chain_request_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd          = '0;
   logic [7:0]  req_reg_address  = '0;
   logic [15:0] req_write_value  = '0;
   logic [4:0]  req_module_index = '0;
   logic [7:0]  req_resp_byte    = '0;
   logic        req_resp_last    = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_frame_last;
   logic        rsp_echo_ok;
   logic        rsp_crc_ok;
   logic        rsp_alive_ok;
   logic [7:0]  rsp_found_count;
   logic        psel             = 1'b0;
   logic        penable          = 1'b0;
   logic        pwrite           = 1'b0;
   logic [4:0]  paddr            = '0;
   logic [31:0] pwdata           = '0;
   logic [31:0] prdata;
   logic        pready;

   daisy_chain_frame_build_check_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_reg_address  (req_reg_address),
      .req_write_value  (req_write_value),
      .req_module_index (req_module_index),
      .req_resp_byte    (req_resp_byte),
      .req_resp_last    (req_resp_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_frame_byte   (rsp_frame_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_echo_ok      (rsp_echo_ok),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_alive_ok     (rsp_alive_ok),
      .rsp_found_count  (rsp_found_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 10 ns period, low half first
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mirror of the register file, updated at each register write
   dcfb_pkg::cfg_type chain_cfg = '{load_queue_opcode: dcfb_pkg::RESET_LOAD_QUEUE,
                                    hello_opcode:      dcfb_pkg::RESET_HELLO,
                                    write_all_opcode:  dcfb_pkg::RESET_WRITE_ALL,
                                    read_all_opcode:   dcfb_pkg::RESET_READ_ALL,
                                    module_count:      dcfb_pkg::RESET_MODULE_CNT};

   // Response tracking state of the block, as predicted
   dcfb_pkg::cmd_type pend_cmd = dcfb_pkg::CMD_ENUMERATE;
   logic [7:0] sent_bytes [5];
   logic [6:0] resp_pos    = '0;
   logic [7:0] resp_crc    = '0;
   logic [7:0] prev_byte [2] = '{8'h00, 8'h00};
   logic       echo_good   = 1'b1;
   logic [7:0] hello_count = '0;

   chain_request_type    request_q [$];        // requests waiting to be offered
   dcfb_pkg::result_type frame_report_q [$];   // frame bytes and reports still due

   // Stimulus-side view of the last request, used to shape responses
   dcfb_pkg::cmd_type gen_kind = dcfb_pkg::CMD_ENUMERATE;
   logic [7:0] gen_sent [5];

   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          error_count    = 0;
   int          stim_count     = 0;
   int unsigned cycle_count    = 0;
   logic        hold_armed     = 1'b0;
   int unsigned hold_count     = 0;
   wire         hold_active    = hold_armed && (hold_count < HOLD_CYCLES);

   // Reflected CRC-8, one bit per pass, LSB first
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++)
         c = {1'b0, c[7:1]} ^ (dcfb_pkg::CRC_POLY & {8{c[0]}});
      return c;
   endfunction

   function automatic logic [7:0] alive_count(input dcfb_pkg::cmd_type kind);
      if (kind == dcfb_pkg::CMD_WRITE_DEVICE || kind == dcfb_pkg::CMD_READ_DEVICE)
         return 8'd1;
      return {3'b000, chain_cfg.module_count};
   endfunction

   // Module bytes, their count and the length byte of one request's frame
   function automatic void module_frame(input dcfb_pkg::cmd_type c, input logic [7:0] addr,
                                        input logic [15:0] val, input logic [4:0] idx,
                                        output logic [5:0][7:0] mb, output int nm,
                                        output logic [7:0] len);
      mb = '0;
      case (c)
         dcfb_pkg::CMD_ENUMERATE: begin
            mb[0] = chain_cfg.hello_opcode;
            nm    = 3;
            len   = dcfb_pkg::HELLO_LEN;
         end
         dcfb_pkg::CMD_WRITE_BCAST, dcfb_pkg::CMD_WRITE_DEVICE: begin
            mb[0] = (c == dcfb_pkg::CMD_WRITE_BCAST) ? chain_cfg.write_all_opcode
                                                     : {idx, dcfb_pkg::DEV_WRITE_TAG};
            mb[1] = addr;
            mb[2] = val[7:0];
            mb[3] = val[15:8];
            mb[4] = crc8_fold(crc8_fold(crc8_fold(crc8_fold(8'h00, mb[0]), mb[1]), mb[2]),
                              mb[3]);
            nm    = 6;
            len   = dcfb_pkg::WRITE_LEN;
         end
         default: begin
            mb[0] = (c == dcfb_pkg::CMD_READ_BCAST) ? chain_cfg.read_all_opcode
                                                    : {idx, dcfb_pkg::DEV_READ_TAG};
            mb[1] = addr;
            mb[3] = crc8_fold(crc8_fold(crc8_fold(8'h00, mb[0]), mb[1]), mb[2]);
            nm    = 5;
            len   = (c == dcfb_pkg::CMD_READ_BCAST) ?
                    dcfb_pkg::READ_ALL_BASE_LEN + {2'b00, chain_cfg.module_count, 1'b0}
                    : dcfb_pkg::READ_DEVICE_LEN;
         end
      endcase
   endfunction

   function automatic void clear_response();
      resp_pos     = '0;
      resp_crc     = '0;
      prev_byte[0] = '0;
      prev_byte[1] = '0;
      echo_good    = 1'b1;
      hello_count  = '0;
   endfunction

   function automatic void queue_frame_byte(input logic [7:0] b, input logic is_last);
      dcfb_pkg::result_type r;
      r            = '0;
      r.frame_byte = b;
      r.frame_last = is_last;
      frame_report_q.push_back(r);
   endfunction

   // Advance the predicted state by one accepted request
   function automatic void build_frame_and_check(input chain_request_type rq);
      logic [5:0][7:0]      mb;
      int                   nm;
      logic [7:0]           len;
      logic [7:0]           alive_want;
      dcfb_pkg::result_type r;
      if (rq.cmd <= dcfb_pkg::CMD_READ_DEVICE) begin
         module_frame(dcfb_pkg::cmd_type'(rq.cmd), rq.reg_address, rq.write_value,
                      rq.module_index, mb, nm, len);
         for (int i = 0; i < 5; i++)
            sent_bytes[i] = mb[i];
         pend_cmd = dcfb_pkg::cmd_type'(rq.cmd);
         clear_response();
         queue_frame_byte(chain_cfg.load_queue_opcode, 1'b0);
         queue_frame_byte(len, 1'b0);
         for (int i = 0; i < nm; i++)
            queue_frame_byte(mb[i], i == nm - 1);
      end else if (rq.cmd == dcfb_pkg::CMD_RESPONSE) begin
         if (resp_pos < dcfb_pkg::POS_ECHO_END && rq.resp_byte != sent_bytes[resp_pos])
            echo_good = 1'b0;
         if (resp_pos == dcfb_pkg::POS_CAPTURE)
            hello_count = rq.resp_byte;
         if (resp_pos >= dcfb_pkg::POS_CAPTURE)
            resp_crc = crc8_fold(resp_crc, prev_byte[1]);
         if (!rq.resp_last) begin
            prev_byte[1] = prev_byte[0];
            prev_byte[0] = rq.resp_byte;
            if (resp_pos != dcfb_pkg::POS_MAX)
               resp_pos = resp_pos + 7'd1;
         end else begin
            r             = '0;
            r.result_kind = 1'b1;
            alive_want    = alive_count(pend_cmd);
            case (pend_cmd)
               dcfb_pkg::CMD_ENUMERATE: begin
                  r.found_count = hello_count;
               end
               dcfb_pkg::CMD_WRITE_BCAST, dcfb_pkg::CMD_WRITE_DEVICE: begin
                  r.echo_ok  = echo_good && (resp_pos >= dcfb_pkg::POS_ECHO_END);
                  r.alive_ok = (rq.resp_byte == alive_want);
               end
               default: begin
                  r.crc_ok   = (resp_crc == prev_byte[0]);
                  r.alive_ok = (rq.resp_byte == alive_want);
               end
            endcase
            frame_report_q.push_back(r);
            clear_response();
         end
      end
   endfunction

   function automatic chain_request_type random_request();
      chain_request_type rq;
      rq.cmd          = 3'($urandom);
      rq.reg_address  = 8'($urandom);
      rq.write_value  = 16'($urandom);
      rq.module_index = 5'($urandom);
      rq.resp_byte    = 8'($urandom);
      rq.resp_last    = 1'($urandom);
      return rq;
   endfunction

   // Queue one command request and note what it will send
   function automatic void push_request(input dcfb_pkg::cmd_type c, input logic [7:0] addr,
                                        input logic [15:0] val, input logic [4:0] idx);
      chain_request_type rq;
      logic [5:0][7:0]   mb;
      int                nm;
      logic [7:0]        len;
      rq              = random_request();
      rq.cmd          = c;
      rq.reg_address  = addr;
      rq.write_value  = val;
      rq.module_index = idx;
      module_frame(c, addr, val, idx, mb, nm, len);
      for (int i = 0; i < 5; i++)
         gen_sent[i] = mb[i];
      gen_kind = c;
      request_q.push_back(rq);
      stim_count++;
   endfunction

   function automatic void push_resp_byte(input logic [7:0] b, input logic is_last);
      chain_request_type rq;
      rq           = random_request();
      rq.cmd       = dcfb_pkg::CMD_RESPONSE;
      rq.resp_byte = b;
      rq.resp_last = is_last;
      request_q.push_back(rq);
      stim_count++;
   endfunction

   function automatic void push_noise(input logic [2:0] code);
      chain_request_type rq;
      rq     = random_request();
      rq.cmd = code;
      request_q.push_back(rq);
   endfunction

   // Queue a response stream of n bytes. Shaped: sent-byte echo on writes, valid
   // CRC on reads, the right alive count but on hello, an occasional bit flip.
   // Unclosed streams leave the last flag low so the next request abandons them.
   function automatic void push_response(input int n, input bit shaped, input bit closed);
      logic [7:0] b [$];
      logic [7:0] crc;
      for (int i = 0; i < n; i++)
         b.push_back(8'($urandom));
      if (shaped) begin
         if (gen_kind == dcfb_pkg::CMD_WRITE_BCAST || gen_kind == dcfb_pkg::CMD_WRITE_DEVICE) begin
            for (int i = 0; i < 5 && i < n - 1; i++)
               b[i] = gen_sent[i];
         end
         if ((gen_kind == dcfb_pkg::CMD_READ_BCAST || gen_kind == dcfb_pkg::CMD_READ_DEVICE)
             && n >= 2) begin
            crc = 8'h00;
            for (int i = 0; i < n - 2; i++)
               crc = crc8_fold(crc, b[i]);
            b[n-2] = crc;
         end
         if (gen_kind != dcfb_pkg::CMD_ENUMERATE)
            b[n-1] = alive_count(gen_kind);
         if ($urandom_range(4) == 0)
            b[$urandom_range(n - 1)] ^= 8'h01 << $urandom_range(7);
      end
      for (int i = 0; i < n; i++)
         push_resp_byte(b[i], closed && (i == n - 1));
   endfunction

   // Mostly well-formed request and response exchanges, with abandoned
   // streams, stray responses, ignored codes and the odd overlong stream
   task automatic run_random_phase(input int n);
      int                start;
      int                pick;
      int                len;
      dcfb_pkg::cmd_type c;
      logic [7:0]        addr;
      logic [15:0]       val;
      logic [4:0]        idx;
      start = stim_count;
      while (stim_count - start < n) begin
         pick = $urandom_range(99);
         c    = dcfb_pkg::cmd_type'($urandom_range(4));
         addr = 8'($urandom);
         val  = 16'($urandom);
         idx  = 5'($urandom);
         if ($urandom_range(7) == 0) begin
            addr = 8'hFF;
            val  = 16'hFFFF;
            idx  = 5'h1F;
         end
         if (pick < 75) begin
            push_request(c, addr, val, idx);
            case (c)
               dcfb_pkg::CMD_ENUMERATE: len = $urandom_range(3, 6);
               dcfb_pkg::CMD_WRITE_BCAST,
               dcfb_pkg::CMD_WRITE_DEVICE: len = $urandom_range(6, 7);
               default: len = $urandom_range(4, 4 + 2 * chain_cfg.module_count);
            endcase
            push_response(len, 1'b1, 1'b1);
            // Check a second response against the same request
            if ($urandom_range(9) == 0)
               push_response($urandom_range(1, 7), 1'b1, 1'b1);
         end else if (pick < 85) begin
            push_request(c, addr, val, idx);
            push_response($urandom_range(1, 4), 1'b0, 1'b0);
         end else if (pick < 94) begin
            push_response($urandom_range(1, 6), 1'b0, 1'b1);
         end else if (pick < 98) begin
            push_noise($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7);
         end else begin
            // Overlong stream drives the byte position into saturation
            push_response($urandom_range(130, 140), 1'b1, 1'b1);
         end
      end
   endtask

   // Hold until every request is taken and every result is back, then let
   // trailing bytes that cause no result settle
   task automatic wait_drained();
      while (request_q.size() != 0 || req_valid || frame_report_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register, then read it back
   task automatic csr_write(input dcfb_pkg::reg_index_type ri, input logic [7:0] value);
      logic [31:0] readback;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {ri, 2'b00};
      pwdata  <= {24'h000000, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (ri)
         dcfb_pkg::REG_LOAD_QUEUE:   chain_cfg.load_queue_opcode = value;
         dcfb_pkg::REG_HELLO:        chain_cfg.hello_opcode      = value;
         dcfb_pkg::REG_WRITE_ALL:    chain_cfg.write_all_opcode  = value;
         dcfb_pkg::REG_READ_ALL:     chain_cfg.read_all_opcode   = value;
         dcfb_pkg::REG_MODULE_COUNT: chain_cfg.module_count      = value[4:0];
         default: ;
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== {24'h000000, value}) begin
         $display("%0t: register %s readback mismatch, expected %0h, actual %0h",
                  $time, ri.name(), {24'h000000, value}, readback);
         error_count++;
      end
   endtask

   task automatic load_config(input logic [7:0] lq, input logic [7:0] hello,
                              input logic [7:0] wr_all, input logic [7:0] rd_all,
                              input logic [4:0] count);
      csr_write(dcfb_pkg::REG_LOAD_QUEUE, lq);
      csr_write(dcfb_pkg::REG_HELLO, hello);
      csr_write(dcfb_pkg::REG_WRITE_ALL, wr_all);
      csr_write(dcfb_pkg::REG_READ_ALL, rd_all);
      csr_write(dcfb_pkg::REG_MODULE_COUNT, {3'b000, count});
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Request driver: predict on each accepted request, then offer the next
   // one unless the sender idles this cycle. A stalled request stays put.
   always @(posedge clock) begin
      chain_request_type rq;
      logic              offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            build_frame_and_check({req_cmd, req_reg_address, req_write_value,
                                   req_module_index, req_resp_byte, req_resp_last});
         if (!req_valid || !req_stall) begin
            offer = (request_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               rq               = request_q.pop_front();
               req_cmd          <= rq.cmd;
               req_reg_address  <= rq.reg_address;
               req_write_value  <= rq.write_value;
               req_module_index <= rq.module_index;
               req_resp_byte    <= rq.resp_byte;
               req_resp_last    <= rq.resp_last;
            end
            req_valid <= offer;
         end
      end
   end

   // Result monitor: check each accepted result against the oldest one due,
   // then pick the stall for the next cycle
   always @(posedge clock) begin
      dcfb_pkg::result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frame_report_q.size() == 0) begin
               $display("%0t: result with none due, expected nothing, actual kind %0b byte %0h",
                        $time, rsp_result_kind, rsp_frame_byte);
               error_count++;
            end else begin
               want = frame_report_q.pop_front();
               compare_field("result_kind", {7'd0, want.result_kind}, {7'd0, rsp_result_kind});
               compare_field("frame_byte", want.frame_byte, rsp_frame_byte);
               compare_field("frame_last", {7'd0, want.frame_last}, {7'd0, rsp_frame_last});
               compare_field("echo_ok", {7'd0, want.echo_ok}, {7'd0, rsp_echo_ok});
               compare_field("crc_ok", {7'd0, want.crc_ok}, {7'd0, rsp_crc_ok});
               compare_field("alive_ok", {7'd0, want.alive_ok}, {7'd0, rsp_alive_ok});
               compare_field("found_count", want.found_count, rsp_found_count);
            end
         end
         rsp_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Long receiver hold-off, counted here once armed
   always @(posedge clock) begin
      if (hold_active)
         hold_count <= hold_count + 1;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("daisy_chain_frame_build_check_top_test failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: every command, field extremes, short, repeated, abandoned
      // and ignored traffic under the reset settings. Open with a request so
      // the echo check never sees unwritten bytes.
      push_request(dcfb_pkg::CMD_ENUMERATE, 8'($urandom), 16'($urandom), 5'($urandom));
      push_response(4, 1'b1, 1'b1);
      push_request(dcfb_pkg::CMD_WRITE_BCAST, 8'h00, 16'h0000, 5'h00);
      push_response(6, 1'b1, 1'b1);
      push_response(1, 1'b0, 1'b1);
      push_request(dcfb_pkg::CMD_WRITE_DEVICE, 8'hFF, 16'hFFFF, 5'h1F);
      push_response(2, 1'b0, 1'b1);
      push_request(dcfb_pkg::CMD_READ_BCAST, 8'hA5, 16'h5A5A, 5'h0A);
      push_response(5, 1'b1, 1'b1);
      push_request(dcfb_pkg::CMD_READ_DEVICE, 8'h00, 16'h0000, 5'h00);
      push_response(1, 1'b0, 1'b0);
      push_noise(CMD_SPARE_6);
      push_noise(CMD_SPARE_7);
      push_request(dcfb_pkg::CMD_READ_DEVICE, 8'h3C, 16'hC3C3, 5'h15);
      push_response(3, 1'b0, 1'b1);
      run_random_phase(PHASE_ITEMS);
      wait_drained();

      // Low opcodes, full chain, sender mostly idle
      load_config(8'h00, 8'h00, 8'h00, 8'h00, 5'd31);
      send_idle_pct <= 86;
      run_random_phase(PHASE_ITEMS);
      wait_drained();

      // High opcodes, single module, receiver mostly stalled
      load_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd1);
      send_idle_pct  <= 0;
      recv_stall_pct <= 86;
      run_random_phase(PHASE_ITEMS);
      wait_drained();

      // Random opcodes, empty chain count, both sides idling
      load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 5'd0);
      send_idle_pct  <= 28;
      recv_stall_pct <= 28;
      run_random_phase(PHASE_ITEMS);
      wait_drained();

      // Back pressure: hold the receiver off while requests keep coming
      load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  5'($urandom_range(1, 31)));
      send_idle_pct  <= 0;
      recv_stall_pct <= 0;
      hold_armed     <= 1'b1;
      run_random_phase(PHASE_ITEMS);
      wait_drained();

      if (frame_report_q.size() != 0) begin
         $display("%0t: %0d results never arrived, expected none left, actual %0d",
                  $time, frame_report_q.size(), frame_report_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("daisy_chain_frame_build_check_top_test passed");
      else
         $display("daisy_chain_frame_build_check_top_test failed");
      $finish;
   end

endmodule
